// ===== hw/rtl/dvp_camera_frame_capture_top_defines.svh =====
// Assertion helpers for the camera capture block.
`ifndef DVP_CAMERA_FRAME_CAPTURE_TOP_DEFINES_SVH
`define DVP_CAMERA_FRAME_CAPTURE_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define DVP_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define DVP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/dvp_cap_pkg.sv =====
package dvp_cap_pkg;

  localparam int DATA_BITS  = 8;
  localparam int COUNT_W    = 21;
  localparam int BUDGET_W   = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  localparam int unsigned TICKS_PER_UNIT        = 800;
  localparam int unsigned DEFAULT_TIMEOUT_UNITS = 500;
  localparam logic [BUDGET_W-1:0] DEFAULT_TIMEOUT =
    BUDGET_W'(DEFAULT_TIMEOUT_UNITS * TICKS_PER_UNIT);

  localparam logic [COUNT_W-1:0]  BUFFER_BYTES_RST = COUNT_W'(262144);
  localparam logic [BUDGET_W-1:0] TIMEOUT_RST      = BUDGET_W'(400000);

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_TIMEOUT  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_VSYNC_POL  = 3'd0,
    REG_HREF_POL   = 3'd1,
    REG_PCLK_EDGE  = 3'd2,
    REG_BUF_BYTES  = 3'd3,
    REG_TIMEOUT    = 3'd4
  } reg_idx_t;

endpackage

// ===== hw/rtl/dvp_cap_if.sv =====
interface dvp_cap_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic                             pclk;
  logic                             vsync;
  logic                             href;
  logic [dvp_cap_pkg::DATA_BITS-1:0] pixel_data;

  modport source (output valid, func, pclk, vsync, href, pixel_data, input ready);
  modport sink   (input valid, func, pclk, vsync, href, pixel_data, output ready);
endinterface

interface dvp_cap_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [dvp_cap_pkg::DATA_BITS-1:0] byte_value;
  logic [dvp_cap_pkg::COUNT_W-1:0]   byte_count;
  logic                              last;

  modport source (output valid, kind, byte_value, byte_count, last, input ready);
  modport sink   (input valid, kind, byte_value, byte_count, last, output ready);
endinterface

// ===== hw/rtl/dvp_camera_frame_capture_top.sv =====
// A word's result is registered and shows in the cycle after the word is accepted.
// One word per cycle unless stalled; tick work is one pass from input to result register.
// Input is stalled only while a result sits in the output register and is not taken.
// Reset (rst, synchronous, active high) puts the capture idle, clears the counters
// and loads the register defaults; no memory, so no clearing pass.
`include "dvp_camera_frame_capture_top_defines.svh"

module dvp_camera_frame_capture_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dvp_cap_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dvp_cap_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dvp_cap_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  dvp_cap_in_if.sink                          samp,
  dvp_cap_out_if.source                       res
);
  import dvp_cap_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_WAIT_INACT  = 3'd1,
    PH_WAIT_ACT    = 3'd2,
    PH_WAIT_INACT2 = 3'd3,
    PH_CAPTURE     = 3'd4
  } phase_t;

  // configuration
  logic                vsync_pol;
  logic                href_pol;
  logic                sample_on_rising;
  logic [COUNT_W-1:0]  buffer_bytes;
  logic [BUDGET_W-1:0] timeout_ticks;

  // capture state
  phase_t              phase, phase_next;
  logic                prev_pclk, prev_pclk_next;
  logic [BUDGET_W-1:0] budget_left, budget_left_next;
  logic [COUNT_W-1:0]  bytes_taken, bytes_taken_next;

  // result register
  logic                out_valid;
  kind_t               out_kind;
  logic [DATA_BITS-1:0] out_value;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;

  logic                emit;
  kind_t               kind_next;
  logic [DATA_BITS-1:0] value_next;
  logic [COUNT_W-1:0]  count_next;
  logic                last_next;

  logic                in_take;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic                vs_active, hr_active, pclk_edge, waiting, take_byte;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_VSYNC_POL: prdata = APB_DATA_W'(vsync_pol);
      REG_HREF_POL:  prdata = APB_DATA_W'(href_pol);
      REG_PCLK_EDGE: prdata = APB_DATA_W'(sample_on_rising);
      REG_BUF_BYTES: prdata = APB_DATA_W'(buffer_bytes);
      REG_TIMEOUT:   prdata = timeout_ticks;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vsync_pol         <= 1'b1;
      href_pol          <= 1'b1;
      sample_on_rising  <= 1'b1;
      buffer_bytes      <= BUFFER_BYTES_RST;
      timeout_ticks     <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VSYNC_POL: vsync_pol         <= pwdata[0];
        REG_HREF_POL:  href_pol          <= pwdata[0];
        REG_PCLK_EDGE: sample_on_rising  <= pwdata[0];
        REG_BUF_BYTES: buffer_bytes      <= pwdata[COUNT_W-1:0];
        REG_TIMEOUT:   timeout_ticks     <= pwdata;
        default: ;
      endcase
    end
  end

  // accept while the result register is free or being drained
  assign samp.ready = !out_valid || res.ready;
  assign in_take    = samp.valid && samp.ready;

  assign vs_active = (samp.vsync == vsync_pol);
  assign hr_active = (samp.href == href_pol);
  assign pclk_edge = (samp.pclk != prev_pclk) && (samp.pclk == sample_on_rising);

  always_comb begin
    phase_next       = phase;
    prev_pclk_next   = prev_pclk;
    budget_left_next = budget_left;
    bytes_taken_next = bytes_taken;
    emit             = 1'b0;
    kind_next        = KIND_BYTE;
    value_next       = '0;
    count_next       = '0;
    last_next        = 1'b0;
    waiting          = 1'b0;
    take_byte        = 1'b0;

    if (samp.func) begin
      // rearm; pins ignored
      budget_left_next = (timeout_ticks == '0) ? DEFAULT_TIMEOUT : timeout_ticks;
      bytes_taken_next = '0;
      phase_next       = PH_WAIT_INACT;
    end else begin
      prev_pclk_next = samp.pclk;
      unique case (phase)
        PH_WAIT_INACT: begin
          if (!vs_active) phase_next = PH_WAIT_ACT;
          else waiting = 1'b1;
        end
        PH_WAIT_ACT: begin
          if (vs_active) phase_next = PH_WAIT_INACT2;
          else waiting = 1'b1;
        end
        PH_WAIT_INACT2: begin
          if (!vs_active) phase_next = PH_CAPTURE;
          else waiting = 1'b1;
        end
        PH_CAPTURE: begin
          if (vs_active) begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            kind_next  = KIND_DONE;
            count_next = bytes_taken;
            last_next  = 1'b1;
          end else if (hr_active && pclk_edge) begin
            if (bytes_taken >= buffer_bytes) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              kind_next  = KIND_OVERFLOW;
              last_next  = 1'b1;
            end else begin
              take_byte        = 1'b1;
              emit             = 1'b1;
              kind_next        = KIND_BYTE;
              value_next       = samp.pixel_data;
              count_next       = bytes_taken;
              bytes_taken_next = bytes_taken + COUNT_W'(1);
            end
          end else begin
            waiting = 1'b1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      if (waiting) begin
        if (budget_left == '0) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          kind_next  = KIND_TIMEOUT;
          last_next  = 1'b1;
        end else begin
          budget_left_next = budget_left - BUDGET_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      prev_pclk   <= 1'b0;
      budget_left <= '0;
      bytes_taken <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_take) begin
        phase       <= phase_next;
        prev_pclk   <= prev_pclk_next;
        budget_left <= budget_left_next;
        bytes_taken <= bytes_taken_next;
        out_valid   <= emit;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload holds until the next result replaces it
  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      out_kind  <= kind_next;
      out_value <= value_next;
      out_count <= count_next;
      out_last  <= last_next;
    end
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_kind;
  assign res.byte_value = out_value;
  assign res.byte_count = out_count;
  assign res.last       = out_last;

  `DVP_ASSERT_NEXT(a_end_goes_idle, in_take && emit && last_next, phase == PH_IDLE, "capture end did not return to idle")
  `DVP_ASSERT_NEXT(a_count_step, in_take && take_byte, bytes_taken == $past(bytes_taken) + COUNT_W'(1), "byte count did not advance")
  `DVP_ASSERT_NOW(a_last_kind, out_valid, out_last == (out_kind != KIND_BYTE), "last flag disagrees with result kind")

endmodule
